/* hdl/cfsi_pkg.sv */
`default_nettype none
package cfsi_pkg;
    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int CNT_W = 32;
    localparam int FP_W = 64;
    localparam int KEY_W = 32;
    localparam int SIZE_W = 17;
    localparam int LIM_W = 11;
    localparam int FPB_W = 7;
    localparam logic [LIM_W-1:0] PROBE_CAP = 11'd1024;
    localparam logic [1:0] REG_FPB = 2'd0;
    localparam logic [1:0] REG_SIZE = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD1, ST_MOD2, ST_ADDR, ST_READ, ST_CHECK, ST_RMOD, ST_RADDR,
        ST_WRITE, ST_OUT, ST_CLEAR
    } state_t;

    typedef struct packed {
        logic                start;
        logic [KEY_W-1:0]    dividend;
        logic [SIZE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic [SIZE_W-1:0]   rem;
    } div_rsp_t;
endpackage
`default_nettype wire

/* hdl/cfsi_mod.sv */
`default_nettype none
// restoring remainder, one quotient bit per cycle
module cfsi_mod
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfsi_pkg::div_req_t req,
    output cfsi_pkg::div_rsp_t      rsp
);
    localparam int W = cfsi_pkg::KEY_W;
    logic [5:0] cnt_reg, cnt_next;
    logic [W-1:0] dvd_reg, dvd_next;
    logic [cfsi_pkg::SIZE_W-1:0] dvs_reg, dvs_next;
    logic [cfsi_pkg::SIZE_W:0] rem_reg, rem_next;
    logic [cfsi_pkg::SIZE_W:0] sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        sh = {rem_reg[cfsi_pkg::SIZE_W-1:0], dvd_reg[W-1]};
        if (req.start)
        begin
            cnt_next = 6'(W);
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 6'd1;
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            rem_next = (sh >= {1'b0, dvs_reg}) ? sh - {1'b0, dvs_reg} : sh;
        end
    end

    // busy from the count alone, so a caller may start on the idle response
    assign rsp.busy = (cnt_reg != '0);
    assign rsp.rem  = rem_reg[cfsi_pkg::SIZE_W-1:0];
endmodule
`default_nettype wire

/* hdl/cfsi_store.sv */
`default_nettype none
// slot memory: used bit and print in one word, one shared address for the registered read and the write
module cfsi_store
#(
    parameter int TABLE_DEPTH = cfsi_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rd_en,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  wire logic                           wr_used,
    input  wire logic [cfsi_pkg::FP_W-1:0]      wr_print,
    output logic                                rd_used,
    output logic [cfsi_pkg::FP_W-1:0]           rd_print
);
    logic [cfsi_pkg::FP_W:0] mem [TABLE_DEPTH];
    logic [cfsi_pkg::FP_W:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= {wr_used, wr_print};
        if (rd_en)
            q_reg <= mem[addr];
    end

    assign rd_used  = q_reg[cfsi_pkg::FP_W];
    assign rd_print = q_reg[cfsi_pkg::FP_W-1:0];
endmodule
`default_nettype wire

/* hdl/compacted_fingerprint_set_insert.sv */
`default_nettype none
// Hash-compaction visited set. Each request takes a fingerprint, home key, random pick and
// permanent flag, probes slots (h1 + p*h2) mod the table size in a single-port slot memory
// and returns one result with the running counters. After reset a clearing pass writes every
// slot of the memory, during which no request is taken. Per accepted request, in order: the
// two key remainders (from a shared bit-serial remainder unit), the first probe (memory read,
// compare), each further probe (address remainder, read, compare), the pick remainder and
// then the address remainder when the probe limit forces an overwrite, a write of the slot
// unless the print was found, and the output state, which then returns to idle before the
// next request is taken. Requests are taken one at a time; the result sits in an output
// register until taken, and a following request stalls in its output cycle while the
// earlier result is still waiting.
module compacted_fingerprint_set_insert
#(
    parameter int TABLE_DEPTH = cfsi_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] fingerprint,
    input  wire logic [31:0] home_key,
    input  wire logic [31:0] random_pick,
    input  wire logic        permanent,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic             overwrote,
    output logic [15:0]      slot_index,
    output logic [10:0]      probes_used,
    output logic [31:0]      visited_count,
    output logic [31:0]      reduced_count,
    output logic [31:0]      collision_count,
    output logic [31:0]      overwrite_count
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = cfsi_pkg::SIZE_W;
    localparam int LW = cfsi_pkg::LIM_W;
    localparam logic [AW:0] DEPTH_V = (AW+1)'(TABLE_DEPTH);

    // configuration registers
    logic [cfsi_pkg::FPB_W-1:0] fpb_reg;
    logic [SW-1:0] tsize_reg;
    logic [LW-1:0] limit_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpb_reg   <= 7'd40;
            tsize_reg <= 17'd65521;
            limit_reg <= 11'd16;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                cfsi_pkg::REG_FPB:   fpb_reg   <= pwdata[6:0];
                cfsi_pkg::REG_SIZE:  tsize_reg <= pwdata[16:0];
                cfsi_pkg::REG_LIMIT: limit_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cfsi_pkg::REG_FPB:   prdata = {25'd0, fpb_reg};
            cfsi_pkg::REG_SIZE:  prdata = {15'd0, tsize_reg};
            cfsi_pkg::REG_LIMIT: prdata = {21'd0, limit_reg};
            default:             prdata = '0;
        endcase
    end

    // effective settings, to be kept fixed by the user for the duration of a request; the block does not latch them
    logic [SW-1:0] size_eff;
    logic [LW-1:0] lim_eff;
    logic [63:0] mask;
    always_comb
    begin
        size_eff = tsize_reg;
        if (tsize_reg < 17'd3)
            size_eff = 17'd3;
        if (int'(tsize_reg) > TABLE_DEPTH)
            size_eff = SW'(TABLE_DEPTH);
        lim_eff = limit_reg;
        if (limit_reg == '0)
            lim_eff = 11'd1;
        if (limit_reg > cfsi_pkg::PROBE_CAP)
            lim_eff = cfsi_pkg::PROBE_CAP;
        if (fpb_reg == '0)
            mask = '0;
        else if (fpb_reg >= 7'd64)
            mask = '1;
        else
            mask = ~64'd0 << (7'd64 - fpb_reg);
    end

    cfsi_pkg::state_t state_reg, state_next;
    logic [63:0] print_reg, print_next;
    logic [31:0] key_reg, key_next, rnd_reg, rnd_next;
    logic perm_reg, perm_next;
    logic [SW-1:0] h1_reg, h1_next, h2_reg, h2_next, h_reg, h_next;
    logic [LW-1:0] probe_reg, probe_next;
    logic [41:0] lin_reg, lin_next;
    logic pres_reg, pres_next, over_reg, over_next;
    logic [AW:0] clr_reg, clr_next;
    logic [31:0] vis_reg, vis_next, red_reg, red_next, col_reg, col_next, ovr_reg, ovr_next;
    logic ov_reg, ov_next;
    logic dv_reg, dv_next;

    cfsi_pkg::div_req_t dreq;
    cfsi_pkg::div_rsp_t drsp;
    logic m_rd, m_wr, m_used, q_used;
    logic [AW-1:0] m_addr;
    logic [63:0] q_print;

    cfsi_mod u_mod (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    cfsi_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store
    (
        .clk(clk), .rd_en(m_rd), .wr_en(m_wr), .addr(m_addr),
        .wr_used(m_used), .wr_print(print_reg),
        .rd_used(q_used), .rd_print(q_print)
    );

    function automatic logic [31:0] sat(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfsi_pkg::ST_CLEAR;
            clr_reg   <= '0;
            vis_reg   <= '0;
            red_reg   <= '0;
            col_reg   <= '0;
            ovr_reg   <= '0;
            ov_reg    <= 1'b0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            vis_reg   <= vis_next;
            red_reg   <= red_next;
            col_reg   <= col_next;
            ovr_reg   <= ovr_next;
            ov_reg    <= ov_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        print_reg <= print_next;
        key_reg   <= key_next;
        rnd_reg   <= rnd_next;
        perm_reg  <= perm_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        h_reg     <= h_next;
        probe_reg <= probe_next;
        lin_reg   <= lin_next;
        pres_reg  <= pres_next;
        over_reg  <= over_next;
    end

    assign in_ready = (state_reg == cfsi_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        print_next = print_reg;
        key_next = key_reg;
        rnd_next = rnd_reg;
        perm_next = perm_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        h_next = h_reg;
        probe_next = probe_reg;
        lin_next = lin_reg;
        pres_next = pres_reg;
        over_next = over_reg;
        clr_next = clr_reg;
        vis_next = vis_reg;
        red_next = red_reg;
        col_next = col_reg;
        ovr_next = ovr_reg;
        ov_next = ov_reg;
        dv_next = 1'b0;
        dreq.start = 1'b0;
        dreq.dividend = key_reg;
        dreq.divisor = size_eff;
        m_rd = 1'b0;
        m_wr = 1'b0;
        m_used = 1'b1;
        m_addr = AW'(h_reg);
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            cfsi_pkg::ST_CLEAR:
            begin
                m_wr = 1'b1;
                m_used = 1'b0;
                m_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == DEPTH_V - 1'b1)
                    state_next = cfsi_pkg::ST_IDLE;
            end
            cfsi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    print_next = fingerprint & mask;
                    key_next = home_key;
                    rnd_next = random_pick;
                    perm_next = permanent;
                    probe_next = '0;
                    pres_next = 1'b0;
                    over_next = 1'b0;
                    dreq.start = 1'b1;
                    dreq.dividend = home_key;
                    state_next = cfsi_pkg::ST_MOD1;
                end
            end
            cfsi_pkg::ST_MOD1:
            begin
                if (!drsp.busy)
                begin
                    h1_next = drsp.rem;
                    h_next = drsp.rem;
                    dreq.start = 1'b1;
                    dreq.divisor = size_eff - 1'b1;
                    state_next = cfsi_pkg::ST_MOD2;
                end
            end
            cfsi_pkg::ST_MOD2:
            begin
                if (!drsp.busy)
                begin
                    h2_next = drsp.rem + 1'b1;
                    state_next = cfsi_pkg::ST_READ;
                end
            end
            cfsi_pkg::ST_ADDR:
            begin
                // h = (h1 + p*h2) mod size, the sum reduced by the shared unit
                if (!drsp.busy)
                begin
                    h_next = drsp.rem;
                    state_next = over_reg ? cfsi_pkg::ST_WRITE : cfsi_pkg::ST_READ;
                end
            end
            cfsi_pkg::ST_READ:
            begin
                m_rd = 1'b1;
                state_next = cfsi_pkg::ST_CHECK;
            end
            cfsi_pkg::ST_CHECK:
            begin
                if (!q_used)
                    state_next = cfsi_pkg::ST_WRITE;
                else if ((q_print & mask) == print_reg)
                begin
                    pres_next = 1'b1;
                    state_next = cfsi_pkg::ST_OUT;
                end
                else
                begin
                    col_next = sat(col_reg);
                    probe_next = probe_reg + 1'b1;
                    if (probe_reg + 1'b1 >= lim_eff)
                    begin
                        over_next = 1'b1;
                        ovr_next = sat(ovr_reg);
                        dreq.start = 1'b1;
                        dreq.dividend = rnd_reg;
                        dreq.divisor = {{(SW-LW){1'b0}}, lim_eff};
                        state_next = cfsi_pkg::ST_RMOD;
                    end
                    else
                    begin
                        lin_next = {{(42-SW){1'b0}}, h1_reg}
                                 + 42'(probe_reg + 1'b1) * 42'(h2_reg);
                        state_next = cfsi_pkg::ST_RADDR;
                    end
                end
            end
            cfsi_pkg::ST_RMOD:
            begin
                if (!drsp.busy)
                begin
                    lin_next = {{(42-SW){1'b0}}, h1_reg}
                             + 42'(drsp.rem[LW-1:0]) * 42'(h2_reg);
                    state_next = cfsi_pkg::ST_RADDR;
                end
            end
            cfsi_pkg::ST_RADDR:
            begin
                // value below 2^28 fits the 32-bit remainder unit
                dreq.start = 1'b1;
                dreq.dividend = lin_reg[31:0];
                state_next = cfsi_pkg::ST_ADDR;
            end
            cfsi_pkg::ST_WRITE:
            begin
                m_wr = 1'b1;
                vis_next = sat(vis_reg);
                if (perm_reg)
                    red_next = sat(red_reg);
                state_next = cfsi_pkg::ST_OUT;
            end
            cfsi_pkg::ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    dv_next = 1'b1;
                    state_next = cfsi_pkg::ST_IDLE;
                end
            end
            default: state_next = cfsi_pkg::ST_IDLE;
        endcase
    end

    // output register, counters copied with the result so a held result stays put
    logic o_pres_reg, o_over_reg;
    logic [15:0] o_slot_reg;
    logic [LW-1:0] o_probe_reg;
    logic [31:0] o_vis_reg, o_red_reg, o_col_reg, o_ovr_reg;
    always_ff @(posedge clk)
    begin
        if (dv_next)
        begin
            o_pres_reg  <= pres_reg;
            o_over_reg  <= over_reg;
            o_slot_reg  <= 16'(h_reg);
            o_probe_reg <= probe_reg;
            o_vis_reg   <= vis_reg;
            o_red_reg   <= red_reg;
            o_col_reg   <= col_reg;
            o_ovr_reg   <= ovr_reg;
        end
    end

    assign out_valid       = ov_reg;
    assign found           = o_pres_reg;
    assign overwrote       = o_over_reg;
    assign slot_index      = o_slot_reg;
    assign probes_used     = o_probe_reg;
    assign visited_count   = o_vis_reg;
    assign reduced_count   = o_red_reg;
    assign collision_count = o_col_reg;
    assign overwrite_count = o_ovr_reg;

    a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == cfsi_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_rd && m_wr))
        else $error("memory read and write together");
    a_vis_mono: assert property (@(posedge clk) disable iff (!rst_n)
        vis_reg >= $past(vis_reg))
        else $error("visit count went down");
    a_probe_lim: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cfsi_pkg::ST_READ |-> probe_reg < lim_eff)
        else $error("probe beyond limit");
    a_dv: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> ov_reg)
        else $error("result lost");
endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = cfsi_pkg::TABLE_DEPTH_DEF;

    // one request as offered on the input channel
    typedef struct packed {
        logic [63:0] fp;
        logic [31:0] key;
        logic [31:0] rnd;
        logic        perm;
    } req_t;

    // one outcome as returned on the output channel
    typedef struct packed {
        logic        present;
        logic        over;
        logic [15:0] slot;
        logic [10:0] probes;
        logic [31:0] visits;
        logic [31:0] perm_visits;
        logic [31:0] collides;
        logic [31:0] overwrites;
    } res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] fingerprint = '0;
    logic [31:0] home_key = '0;
    logic [31:0] random_pick = '0;
    logic        permanent = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic        overwrote;
    logic [15:0] slot_index;
    logic [10:0] probes_used;
    logic [31:0] visited_count;
    logic [31:0] reduced_count;
    logic [31:0] collision_count;
    logic [31:0] overwrite_count;

    compacted_fingerprint_set_insert i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .fingerprint     (fingerprint),
        .home_key        (home_key),
        .random_pick     (random_pick),
        .permanent       (permanent),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .overwrote       (overwrote),
        .slot_index      (slot_index),
        .probes_used     (probes_used),
        .visited_count   (visited_count),
        .reduced_count   (reduced_count),
        .collision_count (collision_count),
        .overwrite_count (overwrite_count)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the hash set: slot flags, stored prints, counters and registers
    bit          slot_used [SLOTS];
    logic [63:0] slot_fp [SLOTS];
    logic [31:0] visits_n, perm_visits_n, collide_n, overwrite_n;
    int unsigned fpb_reg = 40;
    int unsigned size_reg = 65521;
    int unsigned limit_reg = 16;

    req_t pending_reqs[$];
    res_t outcome_q[$];
    req_t recent[$];

    int   n_accepted = 0;
    int   n_results = 0;
    int   n_present = 0;
    int   n_overwrite = 0;
    int   n_mismatch = 0;
    bit   calm = 1'b0;

    // sender and receiver gap counters
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // insert one fingerprint into the shadow set and return its outcome
    function automatic res_t insert_fp(req_t r);
        longint unsigned mask, fpm, size, lim, h1, h2, h, pr;
        bit present, over;
        res_t o;
        if (fpb_reg == 0)
            mask = 0;
        else if (fpb_reg >= 64)
            mask = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            mask = 64'hFFFF_FFFF_FFFF_FFFF << (64 - fpb_reg);
        fpm = r.fp & mask;
        size = size_reg;
        lim = limit_reg;
        if (size < 3)
            size = 3;
        if (size > SLOTS)
            size = SLOTS;
        if (lim == 0)
            lim = 1;
        if (lim > cfsi_pkg::PROBE_CAP)
            lim = cfsi_pkg::PROBE_CAP;
        h1 = r.key % size;
        h2 = 1 + r.key % (size - 1);
        pr = 0;
        present = 1'b0;
        over = 1'b0;
        while (1'b1)
        begin
            h = (h1 + pr * h2) % size;
            if (!slot_used[h])
                break;
            if ((slot_fp[h] & mask) == fpm)
            begin
                present = 1'b1;
                break;
            end
            collide_n = sat_inc(collide_n);
            pr++;
            if (pr >= lim)
            begin
                over = 1'b1;
                overwrite_n = sat_inc(overwrite_n);
                h = (h1 + (r.rnd % lim) * h2) % size;
                break;
            end
        end
        if (!present)
        begin
            slot_used[h] = 1'b1;
            slot_fp[h] = fpm;
            if (r.perm)
                perm_visits_n = sat_inc(perm_visits_n);
            visits_n = sat_inc(visits_n);
        end
        o.present = present;
        o.over = over;
        o.slot = h[15:0];
        o.probes = pr[10:0];
        o.visits = visits_n;
        o.perm_visits = perm_visits_n;
        o.collides = collide_n;
        o.overwrites = overwrite_n;
        return o;
    endfunction

    // driver: takes requests from the pending queue, idles a drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        req_t nxt;
        req_t acc;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                // the block took the request: predict its outcome now
                acc.fp = fingerprint;
                acc.key = home_key;
                acc.rnd = random_pick;
                acc.perm = permanent;
                outcome_q.push_back(insert_fp(acc));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    fingerprint <= nxt.fp;
                    home_key <= nxt.key;
                    random_pick <= nxt.rnd;
                    permanent <= nxt.perm;
                    in_valid <= 1'b1;
                    send_gap <= calm ? 0 : $urandom_range(0, 17);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed once after a few hundred requests, so the
    // block fills and has to stall its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && n_accepted >= 300)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
    end

    // monitor: checks each result against the oldest predicted outcome
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        res_t got;
        int   w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.present = found;
                got.over = overwrote;
                got.slot = slot_index;
                got.probes = probes_used;
                got.visits = visited_count;
                got.perm_visits = reduced_count;
                got.collides = collision_count;
                got.overwrites = overwrite_count;
                n_results++;
                if (outcome_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: result with nothing outstanding", $realtime);
                end
                else
                begin
                    exp_r = outcome_q.pop_front();
                    if (got.present) n_present++;
                    if (got.over) n_overwrite++;
                    if (got !== exp_r)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                        begin
                            $display("%0t: mismatch exp pres=%0d ovw=%0d slot=%0d prb=%0d ",
                                     $realtime, exp_r.present, exp_r.over, exp_r.slot,
                                     exp_r.probes,
                                     "vis=%0d red=%0d col=%0d ovc=%0d",
                                     exp_r.visits, exp_r.perm_visits, exp_r.collides,
                                     exp_r.overwrites);
                            $display("%0t:          got pres=%0d ovw=%0d slot=%0d prb=%0d ",
                                     $realtime, got.present, got.over, got.slot, got.probes,
                                     "vis=%0d red=%0d col=%0d ovc=%0d",
                                     got.visits, got.perm_visits, got.collides,
                                     got.overwrites);
                        end
                    end
                end
                w = calm ? 0 : $urandom_range(0, 17);
                recv_gap <= w;
                out_ready <= (w == 0) && (hold_left == 0);
            end
            else if (hold_left != 0)
                out_ready <= 1'b0;
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // register write: setup then access cycle, shadow updated alongside
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cfsi_pkg::REG_FPB:   fpb_reg = val & 32'h7F;
            cfsi_pkg::REG_SIZE:  size_reg = val & 32'h1FFFF;
            cfsi_pkg::REG_LIMIT: limit_reg = val & 32'h7FF;
            default: ;
        endcase
    endtask

    task automatic set_regs(int unsigned fpb, int unsigned size, int unsigned lim);
        write_reg(cfsi_pkg::REG_FPB, fpb);
        write_reg(cfsi_pkg::REG_SIZE, size);
        write_reg(cfsi_pkg::REG_LIMIT, lim);
    endtask

    task automatic offer(logic [63:0] fp, logic [31:0] key, logic [31:0] rnd, logic perm);
        req_t r;
        r.fp = fp;
        r.key = key;
        r.rnd = rnd;
        r.perm = perm;
        pending_reqs.push_back(r);
        recent.push_back(r);
        if (recent.size() > 64)
            void'(recent.pop_front());
    endtask

    // wait until every request is taken and every outcome has come back
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // random request: half repeat a recent key/print pair so lookups hit
    task automatic random_req();
        req_t old;
        logic [63:0] fp;
        if (recent.size() != 0 && $urandom_range(0, 1) == 0)
        begin
            old = recent[$urandom_range(0, recent.size() - 1)];
            fp = old.fp;
            // sometimes disturb only the low bits, which narrow prints ignore
            if ($urandom_range(0, 3) == 0)
                fp[15:0] = 16'($urandom);
            offer(fp, old.key, $urandom, 1'($urandom_range(0, 1)));
        end
        else
            offer({$urandom, $urandom}, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int unsigned fpb, size, lim;
        visits_n = 0;
        perm_visits_n = 0;
        collide_n = 0;
        overwrite_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes of every input field
        offer(64'h0, 32'h0, 32'h0, 1'b0);
        offer(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        offer(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        offer(64'hFFFF_FFFF_FF00_0000, 32'h0, 32'h1, 1'b1);
        offer(64'hA5A5_5A5A_0000_0000, 32'd65521, 32'h8000_0000, 1'b1);
        drain();

        // tiny table, one probe: present answer and forced overwrites
        calm = 1'b1;
        set_regs(64, 3, 1);
        offer(64'h1111, 32'd0, 32'd5, 1'b1);
        offer(64'h1111, 32'd0, 32'd7, 1'b0);
        offer(64'h2222, 32'd0, 32'hFFFF_FFFF, 1'b1);
        offer(64'h3333, 32'd1, 32'd0, 1'b0);
        offer(64'h4444, 32'd2, 32'd3, 1'b1);
        offer(64'h5555, 32'hFFFF_FFFF, 32'd9, 1'b0);
        drain();

        // zero print width matches everything; below-minimum size and limit
        calm = 1'b0;
        set_regs(0, 0, 0);
        offer(64'hDEAD_BEEF_0000_0001, 32'd12, 32'd1, 1'b1);
        offer(64'h0, 32'd7, 32'd2, 1'b0);
        drain();
        set_regs(1, 2, 1);
        offer(64'h8000_0000_0000_0000, 32'd3, 32'd4, 1'b1);
        offer(64'h7FFF_FFFF_FFFF_FFFF, 32'd3, 32'd4, 1'b1);
        drain();

        // over-range width, size and limit all clamp
        set_regs(127, 131071, 2047);
        for (int i = 0; i < 6; i++)
            offer({$urandom, $urandom}, $urandom, $urandom, 1'($urandom_range(0, 1)));
        drain();

        // full three-slot table at the longest probe limit
        set_regs(64, 3, 1024);
        for (int i = 0; i < 6; i++)
            offer({$urandom, $urandom}, $urandom, $urandom, 1'b1);
        drain();

        // random phases: mostly small tables and short limits, a few large ones
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 3))
                0: fpb = 1;
                1: fpb = 64;
                default: fpb = $urandom_range(1, 64);
            endcase
            if (ph == 3)
                size = 65536;
            else if ($urandom_range(0, 4) == 0)
                size = $urandom_range(3, 65536);
            else
                size = $urandom_range(3, 97);
            lim = (ph == 5) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            calm = (ph == 2);
            set_regs(fpb, size, lim);
            for (int i = 0; i < 185; i++)
                random_req();
            drain();
        end

        $display("requests %0d, results %0d (present %0d, overwritten %0d)",
                 n_accepted, n_results, n_present, n_overwrite);
        $display("covered clamped and tiny tables, zero and full print widths, long stall");
        if (n_mismatch == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // run limit, allowing for the clearing pass and long probe chains
    initial
    begin
        #400_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
